@@ sv/hte_pkg.sv @@
// Shared types and constants for the table-driven Huffman encoder.
// Used by hte_pack, hte_out and huffman_table_encoder_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hte_pkg;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_SYMBOL_COUNT = 256;

    localparam int CODE_WORD_W = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = 4;
    localparam int BURST_W     = MAX_BYTES * BYTE_W;
    localparam int BIT_CNT_W   = 3;
    localparam int BYTE_CNT_W  = 3;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_ENCODE = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    // Bytes completed by one request, first byte in the top bits.
    typedef struct packed {
        logic [BURST_W-1:0]    bytes;
        logic [BYTE_CNT_W-1:0] count;
        logic [BIT_CNT_W-1:0]  pad;
    } hte_burst_t;

endpackage

`default_nettype wire

@@ sv/hte_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hte_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/hte_pack.sv @@
// MSB-first bit packer: holds the partial byte and merges one code into it.
// Depends on hte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hte_pack (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               go,
    input  wire logic                               is_flush,
    input  wire logic [hte_pkg::CODE_WORD_W-1:0]    code,
    input  wire logic [hte_pkg::CODE_LEN_W-1:0]     clen,
    output hte_pkg::hte_burst_t                     burst
);

    import hte_pkg::*;

    localparam int WIN_W = BURST_W + BYTE_W;

    logic [BYTE_W-1:0]    bit_buffer_reg, bit_buffer_next;
    logic [BIT_CNT_W-1:0] bit_count_reg, bit_count_next;

    logic [WIN_W-1:0]      code_ext;
    logic [WIN_W-1:0]      aligned;
    logic [WIN_W-1:0]      window;
    logic [WIN_W-1:0]      rest;
    logic [CODE_LEN_W-1:0] total;
    logic [BYTE_CNT_W-1:0] nbytes;

    always_comb
    begin
        // Put the first code bit at the top of the window, then slide it
        // below the bits already waiting in the buffer.
        code_ext = {code, {BYTE_W{1'b0}}};
        aligned  = code_ext << (CODE_LEN_W'(CODE_WORD_W) - clen);
        window   = {bit_buffer_reg, {BURST_W{1'b0}}} | (aligned >> bit_count_reg);
        total    = CODE_LEN_W'(bit_count_reg) + clen;
        nbytes   = total[CODE_LEN_W-1:BIT_CNT_W];
        rest     = window << {nbytes, 3'b000};

        if (is_flush)
        begin
            burst.bytes     = {bit_buffer_reg, {(BURST_W-BYTE_W){1'b0}}};
            burst.count     = (bit_count_reg != '0) ? BYTE_CNT_W'(1) : '0;
            burst.pad       = BIT_CNT_W'(4'd8 - {1'b0, bit_count_reg});
            bit_buffer_next = '0;
            bit_count_next  = '0;
        end
        else
        begin
            burst.bytes     = window[WIN_W-1:BYTE_W];
            burst.count     = nbytes;
            burst.pad       = '0;
            bit_buffer_next = rest[WIN_W-1:BURST_W];
            bit_count_next  = total[BIT_CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
        end
        else if (go)
        begin
            bit_buffer_reg <= bit_buffer_next;
            bit_count_reg  <= bit_count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hte_out.sv @@
// Output holding register: takes a burst of up to four bytes and hands
// them out one per request. Depends on hte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hte_out (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             load,
    input  wire hte_pkg::hte_burst_t              burst,
    output logic                                  free,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [hte_pkg::BYTE_W-1:0]            out_byte,
    output logic [hte_pkg::BIT_CNT_W-1:0]         pad_bits,
    output logic                                  last
);

    import hte_pkg::*;

    logic [BURST_W-1:0]    hold_reg;
    logic [BYTE_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0]  pad_reg;
    logic                  take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign free      = (cnt_reg == '0) || ((cnt_reg == BYTE_CNT_W'(1)) && take);
    assign out_byte  = hold_reg[BURST_W-1:BURST_W-BYTE_W];
    assign pad_bits  = pad_reg;
    assign last      = (cnt_reg == BYTE_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.count;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - BYTE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= burst.bytes;
            pad_reg  <= burst.pad;
        end
        else if (take)
        begin
            hold_reg <= hold_reg << BYTE_W;
        end
    end

endmodule

`default_nettype wire

@@ sv/huffman_table_encoder_core.sv @@
// Table-driven Huffman encoder with MSB-first byte packing.
// Path: an accepted encode or flush request is held in the registered lookup stage until
// the output register is free, and its first byte is valid once it is loaded there.
// Throughput: one request per cycle while each yields at most one byte and the output is
// not stalled; a request that completes n bytes (at most four) holds the output register until all are taken.
// Reset: packer buffer and all handshake state clear; the code store is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module huffman_table_encoder_core #(
    parameter int MAX_CODE_LEN = hte_pkg::DEF_MAX_CODE_LEN,
    parameter int SYMBOL_COUNT = hte_pkg::DEF_SYMBOL_COUNT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [hte_pkg::BYTE_W-1:0]          symbol,
    input  wire logic [hte_pkg::CODE_WORD_W-1:0]     code_word,
    input  wire logic [hte_pkg::CODE_LEN_W-1:0]      code_length,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [hte_pkg::BYTE_W-1:0]               out_byte,
    output logic [hte_pkg::BIT_CNT_W-1:0]            pad_bits,
    output logic                                     last
);

    import hte_pkg::*;

    // Code lengths never exceed the code word width; the store is sized to
    // the effective limit.
    localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_WORD_W) ? MAX_CODE_LEN : CODE_WORD_W;
    localparam int LEN_W     = $clog2(LEN_LIMIT + 1);
    localparam int ENTRY_W   = LEN_LIMIT + LEN_W;
    localparam int SYM_AW    = $clog2(SYMBOL_COUNT);

    logic                  accept;
    logic                  sym_ok;
    logic                  ram_we;
    logic                  ram_re;
    logic [LEN_W-1:0]      load_len;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_flush_reg;
    logic                  go;
    logic                  free;

    logic [CODE_WORD_W-1:0] lookup_code;
    logic [CODE_LEN_W-1:0]  lookup_len;
    hte_burst_t             burst;

    // A request is accepted whenever the lookup stage is empty or can hand
    // its result to the output register in this cycle.
    assign in_stall = s1_valid_reg && !free;
    assign accept   = in_valid && !in_stall;
    assign go       = s1_valid_reg && free;

    // Symbols outside the store are dropped by both load and encode.
    assign sym_ok = ({1'b0, symbol} < (BYTE_W + 1)'(SYMBOL_COUNT));

    // Overlong code lengths saturate at the limit when they are loaded.
    assign load_len  = (code_length > CODE_LEN_W'(LEN_LIMIT))
                       ? LEN_W'(LEN_LIMIT) : LEN_W'(code_length);
    assign ram_wdata = {code_word[LEN_LIMIT-1:0], load_len};
    assign ram_we    = accept && (req_type == REQ_LOAD) && sym_ok;
    assign ram_re    = accept && (req_type == REQ_ENCODE) && sym_ok;

    // The read port only advances on an accepted encode, so the looked-up
    // entry holds steady while the lookup stage waits on the output.
    hte_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (SYMBOL_COUNT)
    ) u_code_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (symbol[SYM_AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (symbol[SYM_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign lookup_code = CODE_WORD_W'(ram_rdata[ENTRY_W-1:LEN_W]);
    assign lookup_len  = CODE_LEN_W'(ram_rdata[LEN_W-1:0]);

    // Lookup stage: encodes and flushes pass through it in order so that the
    // packer sees them in the order they were accepted. Loads, unknown
    // requests and out-of-range encodes finish at acceptance.
    always_comb
    begin
        s1_valid_next = s1_valid_reg && !go;
        if (accept && (ram_re || (req_type == REQ_FLUSH)))
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flush_reg <= (req_type == REQ_FLUSH);
        end
    end

    // Merge the looked-up code into the partial byte and collect the bytes
    // it completes.
    hte_pack u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .is_flush (s1_flush_reg),
        .code     (lookup_code),
        .clen     (lookup_len),
        .burst    (burst)
    );

    // Completed bytes wait here and leave one per output request.
    hte_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (go),
        .burst     (burst),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .pad_bits  (pad_bits),
        .last      (last)
    );

endmodule

`default_nettype wire
